### rtl/gwm_pkg.sv
// Package for the glob wildcard matcher: pattern limits, wildcard codes,
// configuration register indexes, the config bundle and case folding.
// No dependencies.
package gwm_pkg;

  localparam int MAX_PATTERN_CHARS = 16;
  localparam int LEN_W             = 5;
  localparam int CFG_INDEX_W       = 8;
  localparam int CFG_DATA_W        = 64;

  localparam logic [7:0] WILD_ONE = 8'h3F;  // '?'
  localparam logic [7:0] WILD_ANY = 8'h2A;  // '*'

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PAT_LOW   = 8'd0,
    CFG_PAT_HIGH  = 8'd1,
    CFG_PAT_LEN   = 8'd2,
    CFG_CASE_SENS = 8'd3
  } cfg_index_t;

  typedef struct packed {
    logic [MAX_PATTERN_CHARS-1:0][7:0] pat_bytes;
    logic [LEN_W-1:0]                  pat_len;
    logic                              case_sens;
  } pat_cfg_t;

  // ASCII upper case to lower case when not case sensitive
  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic case_sens);
    logic [7:0] r;
    r = c;
    if (!case_sens && c >= 8'h41 && c <= 8'h5A) r = c | 8'h20;
    return r;
  endfunction

endpackage

### rtl/gwm_nfa_step.sv
// One character step of the glob position set: star closure of the stored set,
// transition and closure again when a byte is present, and the match bit.
// Depends on gwm_pkg.
module gwm_nfa_step #(
  parameter int PATTERN_CHARS = gwm_pkg::MAX_PATTERN_CHARS
) (
  input  gwm_pkg::pat_cfg_t          cfg,
  input  logic [PATTERN_CHARS:0]     set_in,
  input  logic [7:0]                 text_char,
  input  logic                       has_char,
  output logic [PATTERN_CHARS:0]     set_out,
  output logic                       matched
);
  import gwm_pkg::*;

  localparam int SW = PATTERN_CHARS + 1;

  logic [LEN_W-1:0] eff_len;
  logic [SW-1:0]    len_mask;
  logic [SW-1:0]    star_en;
  logic [SW-1:0]    hit_en;
  logic [SW-1:0]    cur;
  logic [SW-1:0]    trans;
  logic [7:0]       text_fold;

  // mask above the length, then each live star also enables its successor
  function automatic logic [SW-1:0] close_set(input logic [SW-1:0] s,
                                               input logic [SW-1:0] mask,
                                               input logic [SW-1:0] star);
    logic [SW-1:0] r;
    r = s & mask;
    for (int i = 0; i < PATTERN_CHARS; i++) begin
      r[i+1] = r[i+1] | (r[i] & star[i]);
    end
    return r;
  endfunction

  always_comb begin
    if (cfg.pat_len > LEN_W'(PATTERN_CHARS)) eff_len = LEN_W'(PATTERN_CHARS);
    else eff_len = cfg.pat_len;
    text_fold = fold_char(text_char, cfg.case_sens);
    len_mask = '0;
    star_en  = '0;
    hit_en   = '0;
    for (int i = 0; i < SW; i++) begin
      len_mask[i] = (LEN_W'(i) <= eff_len);
    end
    for (int i = 0; i < PATTERN_CHARS; i++) begin
      if (LEN_W'(i) < eff_len) begin
        star_en[i] = (cfg.pat_bytes[i] == WILD_ANY);
        hit_en[i]  = (cfg.pat_bytes[i] == WILD_ONE) ||
                     (fold_char(cfg.pat_bytes[i], cfg.case_sens) == text_fold);
      end
    end

    cur   = close_set(set_in, len_mask, star_en);
    trans = '0;
    for (int i = 0; i < PATTERN_CHARS; i++) begin
      if (cur[i]) begin
        if (star_en[i]) trans[i] = 1'b1;
        else if (hit_en[i]) trans[i+1] = 1'b1;
      end
    end

    if (has_char) set_out = close_set(trans, len_mask, star_en);
    else set_out = cur;

    matched = 1'b0;
    for (int i = 0; i < SW; i++) begin
      if (LEN_W'(i) == eff_len) matched = set_out[i];
    end
  end

endmodule

### rtl/glob_wildcard_matcher_unit.sv
// Glob wildcard matcher, top level: config registers, input register,
// position-set register and result register. Depends on gwm_pkg, gwm_nfa_step.
//
// Streams the bytes of a name, one per transfer, and on the transfer marked
// tlast returns one result byte whose bit 0 says whether the whole name matches
// the configured glob pattern ('?' any byte, '*' any run, optional ASCII case
// folding). A transfer with tuser bit 0 low carries no byte. One transfer is
// taken every cycle unless a last transfer would overwrite a result still
// waiting; each result passes through the input register and the result register.
// Configuration writes are taken at any time but must only be issued while
// no name is in flight.
module glob_wildcard_matcher_unit #(
  parameter int PATTERN_CHARS = gwm_pkg::MAX_PATTERN_CHARS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gwm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gwm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] text_char
  input  logic                           s_tuser,   // [0] has_char
  input  logic                           s_tlast,   // last_char
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata    // [0] matched, [7:1] zero
);
  import gwm_pkg::*;

  localparam int SW = PATTERN_CHARS + 1;

  pat_cfg_t      cfg;
  logic          in_valid;
  logic [7:0]    in_char;
  logic          in_has;
  logic          in_last;
  logic [SW-1:0] act;
  logic [SW-1:0] set_next;
  logic          match_next;
  logic          matched;
  logic          fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pat_bytes <= '0;
      cfg.pat_len   <= '0;
      cfg.case_sens <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PAT_LOW:   cfg.pat_bytes[7:0]  <= cfg_data;
        CFG_PAT_HIGH:  cfg.pat_bytes[15:8] <= cfg_data;
        CFG_PAT_LEN:   cfg.pat_len         <= cfg_data[LEN_W-1:0];
        CFG_CASE_SENS: cfg.case_sens       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // the stage moves on unless a result would overwrite one still waiting
  assign fire     = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_has  <= s_tuser;
      in_last <= s_tlast;
    end
  end

  gwm_nfa_step #(
    .PATTERN_CHARS(PATTERN_CHARS)
  ) u_step (
    .cfg       (cfg),
    .set_in    (act),
    .text_char (in_char),
    .has_char  (in_has),
    .set_out   (set_next),
    .matched   (match_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= SW'(1);
    end else if (fire) begin
      act <= in_last ? SW'(1) : set_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_last) matched <= match_next;
  end

  assign m_tdata = {7'b0, matched};

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for glob_wildcard_matcher_unit: directed table, then random names
// against an in-bench model of the live-position set. Depends on gwm_pkg.
module testbench;
  import gwm_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int ITEM_TARGET  = 600;
  localparam int DRAIN_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;

  glob_wildcard_matcher_unit i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the pattern registers and the live-position set
  logic [127:0] pattern_text = '0;
  logic [4:0]   pat_len = '0;
  logic         case_sens = 1'b1;
  logic [16:0]  live_pos = 17'd1;

  bit match_expected_q[$];
  int errors = 0;
  int items_sent = 0;
  int burst_left = 0;
  int cycles = 0;

  typedef struct {
    bit          is_cfg;
    logic [63:0] lo, hi;
    logic [4:0]  len;
    bit          cs;
    logic [7:0]  ch;
    bit          has, last, known, exp;
  } dir_row_t;

  dir_row_t dir_table[$];

  function automatic logic [7:0] pat_byte(input int i);
    return pattern_text[8*i +: 8];
  endfunction

  function automatic int eff_len();
    return (pat_len > 5'd16) ? 16 : int'(pat_len);
  endfunction

  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    if (!case_sens && c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
    return c;
  endfunction

  // drop positions past the end, then let each live star enable its successor
  function automatic logic [16:0] close_positions(input logic [16:0] set, input int len);
    for (int j = 0; j < 17; j++)
      if (j > len) set[j] = 1'b0;
    for (int i = 0; i < len; i++)
      if (set[i] && pat_byte(i) == WILD_ANY) set[i+1] = 1'b1;
    return set;
  endfunction

  function automatic bit match_step(input logic [7:0] ch, input bit has, input bit last,
                                    output bit due);
    int len;
    logic [16:0] cur, nxt;
    logic [7:0] p;
    len = eff_len();
    cur = close_positions(live_pos, len);
    if (has) begin
      nxt = '0;
      for (int i = 0; i < len; i++) begin
        if (cur[i]) begin
          p = pat_byte(i);
          if (p == WILD_ANY) nxt[i] = 1'b1;
          else if (p == WILD_ONE || fold_byte(p) == fold_byte(ch)) nxt[i+1] = 1'b1;
        end
      end
      cur = close_positions(nxt, len);
    end
    due = last;
    if (last) begin
      live_pos = 17'd1;
      return cur[len];
    end
    live_pos = cur;
    return 1'b0;
  endfunction

  task automatic send_item(input logic [7:0] ch, input bit has, input bit last,
                           input bit known, input bit typed_exp);
    int gap;
    bit due, m;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tuser  <= has;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    m = match_step(ch, has, last, due);
    if (due) match_expected_q.push_back(known ? typed_exp : m);
    if (has || last) items_sent++;
  endtask

  task automatic cfg_write(input cfg_index_t idx, input logic [63:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PAT_LOW:   pattern_text[63:0] = val;
      CFG_PAT_HIGH:  pattern_text[127:64] = val;
      CFG_PAT_LEN:   pat_len = val[4:0];
      CFG_CASE_SENS: case_sens = val[0];
      default: ;
    endcase
  endtask

  // only reprogram once the block has drained
  task automatic program_pattern(input logic [63:0] lo, input logic [63:0] hi,
                                 input logic [4:0] len, input bit cs);
    s_tvalid <= 1'b0;
    while (match_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write(CFG_PAT_LOW, lo);
    cfg_write(CFG_PAT_HIGH, hi);
    cfg_write(CFG_PAT_LEN, {59'd0, len});
    cfg_write(CFG_CASE_SENS, {63'd0, cs});
    cfg_valid <= 1'b0;
  endtask

  task automatic add_cfg(input logic [63:0] lo, input logic [63:0] hi,
                         input logic [4:0] len, input bit cs);
    dir_row_t r;
    r = '{is_cfg: 1'b1, lo: lo, hi: hi, len: len, cs: cs, default: '0};
    dir_table.push_back(r);
  endtask

  task automatic add_item(input logic [7:0] ch, input bit has, input bit last,
                          input bit known, input bit exp);
    dir_row_t r;
    r = '{ch: ch, has: has, last: last, known: known, exp: exp, default: '0};
    dir_table.push_back(r);
  endtask

  // a name shaped after the current pattern, with occasional breakage
  task automatic send_name();
    logic [7:0] name_q[$];
    logic [7:0] p, c;
    int mode, len;
    bit tail_empty;
    len = eff_len();
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      repeat ($urandom_range(1, 8)) name_q.push_back(8'($urandom_range(0, 255)));
    end else if (mode != 1) begin
      for (int i = 0; i < len; i++) begin
        p = pat_byte(i);
        if ($urandom_range(0, 11) == 0) begin
          if ($urandom_range(0, 1)) name_q.push_back(8'($urandom_range(0, 255)));
        end else if (p == WILD_ANY) begin
          repeat ($urandom_range(0, 3))
            name_q.push_back($urandom_range(0, 1) ? pat_byte($urandom_range(0, 15))
                                                  : 8'($urandom_range(0, 255)));
        end else if (p == WILD_ONE) begin
          name_q.push_back(8'($urandom_range(0, 255)));
        end else begin
          c = p;
          if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) &&
              $urandom_range(0, 1))
            c = c ^ 8'h20;
          name_q.push_back(c);
        end
      end
    end
    tail_empty = (name_q.size() == 0) || ($urandom_range(0, 7) == 0);
    foreach (name_q[k]) begin
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 0, 0);
      send_item(name_q[k], 1'b1, (k == name_q.size() - 1) && !tail_empty, 0, 0);
    end
    if (tail_empty) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 0, 0);
  endtask

  // receiver stall pattern
  int stall_mode = 0;
  int stall_cnt = 0;
  always @(posedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_cnt = $urandom_range(16, 96);
    end else begin
      stall_cnt = stall_cnt - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= (stall_cnt % 4 == 0);
      default: m_tready <= stall_cnt[0];
    endcase
  end

  always @(posedge clk) begin
    bit exp;
    if (!rst && m_tvalid && m_tready) begin
      if (match_expected_q.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, actual %02h", $time, m_tdata);
        errors++;
      end else begin
        exp = match_expected_q.pop_front();
        if (m_tdata !== {7'd0, exp}) begin
          $display("%0t: matched mismatch, expected %02h, actual %02h",
                   $time, {7'd0, exp}, m_tdata);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    // defaults after reset: empty pattern
    add_item(8'h00, 0, 1, 1, 1);
    add_item("a", 1, 1, 1, 0);
    // "a?*Z", exact case
    add_cfg(64'h0000_0000_5A2A_3F61, 64'd0, 5'd4, 1'b1);
    add_item("a", 1, 0, 0, 0); add_item("b", 1, 0, 0, 0); add_item("Z", 1, 1, 1, 1);
    add_item("a", 1, 0, 0, 0); add_item("b", 1, 1, 1, 0);
    add_item("a", 1, 0, 0, 0); add_item(8'h5C, 0, 0, 0, 0); add_item("x", 1, 0, 0, 0);
    add_item("y", 1, 0, 0, 0); add_item("Z", 1, 1, 0, 0);
    add_item("a", 1, 0, 0, 0); add_item("B", 1, 0, 0, 0); add_item("z", 1, 1, 0, 0);
    // same pattern, letters folded; star in the name taken by the star
    add_cfg(64'h0000_0000_5A2A_3F61, 64'd0, 5'd4, 1'b0);
    add_item("A", 1, 0, 0, 0); add_item("B", 1, 0, 0, 0); add_item("z", 1, 1, 0, 0);
    add_item("a", 1, 0, 0, 0); add_item("q", 1, 0, 0, 0); add_item("*", 1, 0, 0, 0);
    add_item("z", 1, 1, 0, 0);
    // all-ones pattern, oversized length clamps to sixteen
    add_cfg('1, '1, 5'd31, 1'b1);
    add_item(8'hFF, 1, 1, 1, 0);
    // sixteen stars match anything
    add_cfg({8{WILD_ANY}}, {8{WILD_ANY}}, 5'd16, 1'b0);
    add_item(8'h00, 0, 1, 1, 1);
    add_item(8'h00, 1, 1, 0, 0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_table[n]) begin
      if (dir_table[n].is_cfg)
        program_pattern(dir_table[n].lo, dir_table[n].hi, dir_table[n].len, dir_table[n].cs);
      else
        send_item(dir_table[n].ch, dir_table[n].has, dir_table[n].last,
                  dir_table[n].known, dir_table[n].exp);
    end

    items_sent = 0;
    while (items_sent < ITEM_TARGET) begin
      logic [127:0] pat;
      logic [4:0] len;
      if ($urandom_range(0, 7) == 0) begin
        pat = {$urandom, $urandom, $urandom, $urandom};
      end else begin
        for (int i = 0; i < 16; i++) begin
          case ($urandom_range(0, 9))
            0, 1:    pat[8*i +: 8] = WILD_ANY;
            2, 3:    pat[8*i +: 8] = WILD_ONE;
            8:       pat[8*i +: 8] = 8'($urandom_range(0, 255));
            default: pat[8*i +: 8] = ($urandom_range(0, 1) ? 8'h61 : 8'h41) +
                                     8'($urandom_range(0, 1));
          endcase
        end
      end
      len = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                        : 5'($urandom_range(0, 16));
      program_pattern(pat[63:0], pat[127:64], len, 1'($urandom_range(0, 1)));
      repeat ($urandom_range(3, 12)) send_name();
    end

    s_tvalid <= 1'b0;
    while (match_expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
